[rtl/core/slle_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slle_pkg
// Shared widths, operation codes and status codes of the linked list engine.
// ----------------------------------------------------------------------------
package slle_pkg;

  localparam int SLOTS_DEFAULT = 64;

  localparam int MODE_W = 2;
  localparam int POS_W  = 6;
  localparam int VAL_W  = 8;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 6;

  localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRAVERSE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_POS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd3;

endpackage

[rtl/core/slle_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slle_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module slle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold read data while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/static_linked_list_engine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// static_linked_list_engine_core
// Cursor-linked list of bytes kept in a link RAM and a data RAM, with a free
// chain of slots, supporting insert, delete and in-order traverse.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the walk through the link RAM sets the
// time, one link per cycle on its single read port. An insert or a delete
// walks from the head to position p, an error goes straight to its result,
// an unused mode is dropped, and a traverse walks the whole list; each waits
// while the output side does not take results. After reset a clearing pass
// over all SLOTS slots builds the free chain; no item is accepted until it
// is done.
module static_linked_list_engine_core #(
  parameter int SLOTS = slle_pkg::SLOTS_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [slle_pkg::MODE_W-1:0] mode_i,
  input  logic [slle_pkg::POS_W-1:0]  position_i,
  input  logic [slle_pkg::VAL_W-1:0]  value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [slle_pkg::STAT_W-1:0] status_o,
  output logic [slle_pkg::VAL_W-1:0]  item_o,
  output logic [slle_pkg::LEN_W-1:0]  length_o,
  output logic                       last_o
);

  import slle_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam logic [SW-1:0]    HEAD     = SW'(SLOTS - 1);
  localparam logic [SW-1:0]    TAIL     = SW'(SLOTS - 2);
  localparam logic [LEN_W-1:0] CAPACITY = LEN_W'(SLOTS - 2);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_INIT     = 4'd0;
  localparam logic [ST_W-1:0] S_IDLE     = 4'd1;
  localparam logic [ST_W-1:0] S_INS_FREE = 4'd2;
  localparam logic [ST_W-1:0] S_WALK     = 4'd3;
  localparam logic [ST_W-1:0] S_INS_LINK = 4'd4;
  localparam logic [ST_W-1:0] S_DEL_READ = 4'd5;
  localparam logic [ST_W-1:0] S_DEL_FREE = 4'd6;
  localparam logic [ST_W-1:0] S_TRV_HEAD = 4'd7;
  localparam logic [ST_W-1:0] S_TRV_EMIT = 4'd8;
  localparam logic [ST_W-1:0] S_EMIT     = 4'd9;

  logic [ST_W-1:0]   state_q, state_d;
  logic [SW-1:0]     init_q, init_d;
  logic [SW-1:0]     free_q, free_d;
  logic [LEN_W-1:0]  count_q, count_d;
  logic [SW-1:0]     prev_q, prev_d;
  logic [SW-1:0]     fresh_q, fresh_d;
  logic [SW-1:0]     victim_q, victim_d;
  logic [LEN_W-1:0]  left_q, left_d;
  logic              op_del_q, op_del_d;
  logic [VAL_W-1:0]  value_q, value_d;
  logic [STAT_W-1:0] res_status_q, res_status_d;
  logic [VAL_W-1:0]  res_item_q, res_item_d;

  logic              out_valid_q;
  logic [STAT_W-1:0] status_q;
  logic [VAL_W-1:0]  item_q;
  logic [LEN_W-1:0]  length_q;
  logic              last_q;

  logic              out_free;
  logic              out_load;
  logic [STAT_W-1:0] out_status;
  logic [VAL_W-1:0]  out_item;
  logic              out_last;

  logic              lk_we, lk_re;
  logic [SW-1:0]     lk_waddr, lk_raddr, lk_wdata, lk_rdata;
  logic              dt_we, dt_re;
  logic [SW-1:0]     dt_waddr, dt_raddr;
  logic [VAL_W-1:0]  dt_wdata, dt_rdata;

  logic              ins_bad, del_bad, store_full;
  logic [SW-1:0]     init_link;

  slle_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lk_we),
    .waddr_i (lk_waddr),
    .wdata_i (lk_wdata),
    .re_i    (lk_re),
    .raddr_i (lk_raddr),
    .rdata_o (lk_rdata)
  );

  slle_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (dt_we),
    .waddr_i (dt_waddr),
    .wdata_i (dt_wdata),
    .re_i    (dt_re),
    .raddr_i (dt_raddr),
    .rdata_o (dt_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  assign ins_bad    = (position_i == '0) ||
                      ({1'b0, position_i} > ({1'b0, count_q} + (LEN_W + 1)'(1)));
  assign del_bad    = (position_i == '0) || (position_i > count_q);
  assign store_full = (free_q == '0) || (count_q >= CAPACITY);

  // clearing pass: free chain 1 -> 2 -> ... -> SLOTS-2 -> 0, head empty
  assign init_link  = ((init_q == TAIL) || (init_q == HEAD)) ? '0 : init_q + SW'(1);

  always_comb begin
    state_d      = state_q;
    init_d       = init_q;
    free_d       = free_q;
    count_d      = count_q;
    prev_d       = prev_q;
    fresh_d      = fresh_q;
    victim_d     = victim_q;
    left_d       = left_q;
    op_del_d     = op_del_q;
    value_d      = value_q;
    res_status_d = res_status_q;
    res_item_d   = res_item_q;

    lk_we    = 1'b0;
    lk_waddr = prev_q;
    lk_wdata = fresh_q;
    lk_re    = 1'b0;
    lk_raddr = lk_rdata;
    dt_we    = 1'b0;
    dt_waddr = fresh_q;
    dt_wdata = value_q;
    dt_re    = 1'b0;
    dt_raddr = lk_rdata;

    out_load   = 1'b0;
    out_status = res_status_q;
    out_item   = res_item_q;
    out_last   = 1'b1;

    unique case (state_q)
      S_INIT: begin
        lk_we    = 1'b1;
        lk_waddr = init_q;
        lk_wdata = init_link;
        init_d   = init_q + SW'(1);
        if (init_q == HEAD) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          unique case (mode_i)
            MODE_INSERT: begin
              if (ins_bad) begin
                res_status_d = STAT_BAD_POS;
                res_item_d   = '0;
                state_d      = S_EMIT;
              end else if (store_full) begin
                res_status_d = STAT_FULL;
                res_item_d   = '0;
                state_d      = S_EMIT;
              end else begin
                lk_re    = 1'b1;
                lk_raddr = free_q;
                fresh_d  = free_q;
                value_d  = value_i;
                left_d   = position_i - LEN_W'(1);
                op_del_d = 1'b0;
                state_d  = S_INS_FREE;
              end
            end
            MODE_DELETE: begin
              if (del_bad) begin
                res_status_d = STAT_BAD_POS;
                res_item_d   = '0;
                state_d      = S_EMIT;
              end else begin
                lk_re    = 1'b1;
                lk_raddr = HEAD;
                prev_d   = HEAD;
                left_d   = position_i - LEN_W'(1);
                op_del_d = 1'b1;
                state_d  = S_WALK;
              end
            end
            MODE_TRAVERSE: begin
              if (count_q == '0) begin
                res_status_d = STAT_EMPTY;
                res_item_d   = '0;
                state_d      = S_EMIT;
              end else begin
                lk_re    = 1'b1;
                lk_raddr = HEAD;
                left_d   = count_q;
                state_d  = S_TRV_HEAD;
              end
            end
            default: begin
              // unused mode: drop the item
            end
          endcase
        end
      end

      S_INS_FREE: begin
        // pop the fresh slot and store its byte, then start the walk
        free_d   = lk_rdata;
        dt_we    = 1'b1;
        lk_re    = 1'b1;
        lk_raddr = HEAD;
        prev_d   = HEAD;
        state_d  = S_WALK;
      end

      S_WALK: begin
        if (left_q == '0) begin
          if (op_del_q) begin
            victim_d = lk_rdata;
            lk_re    = 1'b1;
            dt_re    = 1'b1;
            state_d  = S_DEL_READ;
          end else begin
            lk_we    = 1'b1;
            lk_waddr = fresh_q;
            lk_wdata = lk_rdata;
            state_d  = S_INS_LINK;
          end
        end else begin
          lk_re  = 1'b1;
          prev_d = lk_rdata;
          left_d = left_q - LEN_W'(1);
        end
      end

      S_INS_LINK: begin
        lk_we        = 1'b1;
        count_d      = count_q + LEN_W'(1);
        res_status_d = STAT_OK;
        res_item_d   = '0;
        state_d      = S_EMIT;
      end

      S_DEL_READ: begin
        // unlink the victim from its predecessor
        lk_we      = 1'b1;
        lk_wdata   = lk_rdata;
        res_item_d = dt_rdata;
        state_d    = S_DEL_FREE;
      end

      S_DEL_FREE: begin
        // push the victim onto the free chain
        lk_we        = 1'b1;
        lk_waddr     = victim_q;
        lk_wdata     = free_q;
        free_d       = victim_q;
        count_d      = count_q - LEN_W'(1);
        res_status_d = STAT_OK;
        state_d      = S_EMIT;
      end

      S_TRV_HEAD: begin
        lk_re   = 1'b1;
        dt_re   = 1'b1;
        state_d = S_TRV_EMIT;
      end

      S_TRV_EMIT: begin
        out_status = STAT_OK;
        out_item   = dt_rdata;
        out_last   = (left_q == LEN_W'(1));
        if (out_free) begin
          out_load = 1'b1;
          left_d   = left_q - LEN_W'(1);
          if (left_q == LEN_W'(1)) begin
            state_d = S_IDLE;
          end else begin
            lk_re = 1'b1;
            dt_re = 1'b1;
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_q      <= '0;
      free_q      <= SW'(1);
      count_q     <= '0;
      op_del_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      init_q   <= init_d;
      free_q   <= free_d;
      count_q  <= count_d;
      op_del_q <= op_del_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q       <= prev_d;
    fresh_q      <= fresh_d;
    victim_q     <= victim_d;
    left_q       <= left_d;
    value_q      <= value_d;
    res_status_q <= res_status_d;
    res_item_q   <= res_item_d;
    if (out_load) begin
      status_q <= out_status;
      item_q   <= out_item;
      length_q <= count_q;
      last_q   <= out_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign item_o      = item_q;
  assign length_o    = length_q;
  assign last_o      = last_q;

endmodule
